// ===== hdl/warq_pkg.sv =====
// Shared types and constants of the windowed ARQ transport engine.
// Used by the front end, the command queue, the back end and the top level.
package warq_pkg;

  localparam logic [2:0] FUNC_PACKET = 3'd0;
  localparam logic [2:0] FUNC_IDLE   = 3'd1;
  localparam logic [2:0] FUNC_SCAN   = 3'd2;
  localparam logic [2:0] FUNC_SUBMIT = 3'd3;
  localparam logic [2:0] FUNC_TAKE   = 3'd4;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_DUPACK = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET = 8'd2;

  typedef enum logic [2:0] {
    OP_DATA,
    OP_ACK,
    OP_DUPACK,
    OP_IDLE,
    OP_SCAN,
    OP_SUBMIT,
    OP_TAKE,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    EMIT_ACK     = 3'd0,
    EMIT_DUPACK  = 3'd1,
    EMIT_RESEND  = 3'd2,
    EMIT_SEND    = 3'd3,
    EMIT_DELIVER = 3'd4
  } emit_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] seq;
    logic [3:0]  win;
    logic [63:0] word;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    emit_e       kind;
    logic [15:0] ack;
    logic [3:0]  free;
    logic [63:0] msg;
  } res_t;

endpackage

// ===== hdl/warq_front.sv =====
// Front end: accepts input beats and turns them into commands for the queue.
// Depends on warq_pkg.
module warq_front import warq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: packet_seq[15:0], packet_window[19:16], message_word[83:20],
  // now_seconds[115:84], zero fill above.
  input  logic [119:0] s_axis_tdata_i,
  // tuser: func[2:0], packet_kind[4:3].
  input  logic [4:0]   s_axis_tuser_i,
  input  logic         full_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  logic [2:0] func;
  logic [1:0] kind;
  op_e        op;
  logic       beat;

  assign func = s_axis_tuser_i[2:0];
  assign kind = s_axis_tuser_i[4:3];

  always_comb begin
    op = OP_NOP;
    case (func)
      FUNC_PACKET: begin
        case (kind)
          KIND_DATA:   op = OP_DATA;
          KIND_ACK:    op = OP_ACK;
          KIND_DUPACK: op = OP_DUPACK;
          default:     op = OP_NOP;
        endcase
      end
      FUNC_IDLE:   op = OP_IDLE;
      FUNC_SCAN:   op = OP_SCAN;
      FUNC_SUBMIT: op = OP_SUBMIT;
      FUNC_TAKE:   op = OP_TAKE;
      default:     op = OP_NOP;
    endcase
  end

  assign s_axis_tready_o = ~full_i;
  assign beat            = s_axis_tvalid_i & ~full_i;
  assign push_o          = beat & (op != OP_NOP);

  assign cmd_o.op   = op;
  assign cmd_o.seq  = s_axis_tdata_i[15:0];
  assign cmd_o.win  = s_axis_tdata_i[19:16];
  assign cmd_o.word = s_axis_tdata_i[83:20];
  assign cmd_o.now  = s_axis_tdata_i[115:84];

endmodule

// ===== hdl/warq_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on warq_pkg.
module warq_cmd_fifo import warq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/warq_back.sv =====
// Back end: executes queued commands on the receive and send stores and
// produces result beats through a hold stage and an output register.
// Depends on warq_pkg.
module warq_back import warq_pkg::*; #(
  parameter int BUFFER_DEPTH = 8,
  parameter int MESSAGE_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] timeout_i,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o,
  output logic       out_last_o
);

  localparam int PW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] DEPTH_C    = CW'(BUFFER_DEPTH);
  localparam logic [3:0]    WIN_RESET  = 4'(BUFFER_DEPTH % 16);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TAKE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_NEW,
    S_FLUSH
  } state_e;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [3:0] free_of(input logic [CW-1:0] used);
    logic [31:0] f;
    f = 32'(BUFFER_DEPTH) - 32'(used);
    return f[3:0];
  endfunction

  logic [MESSAGE_BITS-1:0] recv_mem  [BUFFER_DEPTH];
  logic [MESSAGE_BITS-1:0] send_mem  [BUFFER_DEPTH];
  logic [31:0]             stamp_mem [BUFFER_DEPTH];

  state_e                  state_q;
  cmd_t                    cmd_q;
  logic [PW-1:0]           recv_head_q, recv_tail_q;
  logic [CW-1:0]           recv_used_q;
  logic                    no_room_q;
  logic [15:0]             last_acked_q;
  logic [PW-1:0]           send_head_q, send_tail_q;
  logic [CW-1:0]           send_used_q;
  logic [3:0]              window_q;
  logic                    pending_q;
  logic [MESSAGE_BITS-1:0] pending_word_q;
  logic [PW-1:0]           scan_idx_q;
  logic [CW-1:0]           scan_cnt_q;
  logic                    hold_valid_q;
  res_t                    hold_q;
  logic                    out_valid_q;
  logic                    out_valid_d;
  res_t                    out_q;
  logic                    out_last_q;

  logic [MESSAGE_BITS-1:0] recv_rd_q;
  logic [MESSAGE_BITS-1:0] send_rd_q;
  logic [31:0]             stamp_rd_q;

  logic                    out_free, can_produce, produce, flush_go;
  res_t                    prod_res;
  logic                    recv_room, send_ok, due;
  logic [31:0]             age;
  logic [CW-1:0]           data_used;
  logic                    recv_we, send_we, stamp_we;
  logic [PW-1:0]           stamp_waddr;

  assign out_free    = ~out_valid_q | out_ready_i;
  assign can_produce = ~hold_valid_q | out_free;
  assign recv_room   = (recv_used_q < DEPTH_C);
  assign send_ok     = pending_q && (CMPW'(send_used_q) < CMPW'(window_q)) &&
                       (send_used_q < DEPTH_C);
  assign age         = cmd_q.now - stamp_rd_q;
  assign due         = (age >= 32'(timeout_i));
  assign data_used   = recv_room ? recv_used_q + CW'(1) : recv_used_q;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign flush_go    = (state_q == S_FLUSH) && hold_valid_q && out_free;
  assign out_valid_d = (produce && hold_valid_q) || flush_go ||
                       (out_valid_q && !out_ready_i);

  always_comb begin
    produce     = 1'b0;
    prod_res    = '0;
    recv_we     = 1'b0;
    send_we     = 1'b0;
    stamp_we    = 1'b0;
    stamp_waddr = send_tail_q;
    case (state_q)
      S_EXEC: begin
        case (cmd_q.op)
          OP_DATA: begin
            produce       = can_produce;
            prod_res.kind = EMIT_ACK;
            prod_res.ack  = cmd_q.seq;
            prod_res.free = free_of(data_used);
            recv_we       = can_produce && recv_room;
          end
          OP_IDLE: begin
            if (no_room_q && recv_room) begin
              produce       = can_produce;
              prod_res.kind = EMIT_DUPACK;
              prod_res.ack  = last_acked_q;
              prod_res.free = free_of(recv_used_q);
            end
          end
          default: begin
            produce = 1'b0;
          end
        endcase
      end
      S_TAKE: begin
        produce       = can_produce;
        prod_res.kind = EMIT_DELIVER;
        prod_res.msg  = 64'(recv_rd_q);
      end
      S_SCAN_CHK: begin
        if (due) begin
          produce       = can_produce;
          prod_res.kind = EMIT_RESEND;
          prod_res.msg  = 64'(send_rd_q);
          stamp_we      = can_produce;
          stamp_waddr   = scan_idx_q;
        end
      end
      S_SCAN_NEW: begin
        if (send_ok) begin
          produce       = can_produce;
          prod_res.kind = EMIT_SEND;
          prod_res.msg  = 64'(pending_word_q);
          send_we       = can_produce;
          stamp_we      = can_produce;
        end
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (recv_we) begin
      recv_mem[recv_tail_q] <= cmd_q.word[MESSAGE_BITS-1:0];
    end
    recv_rd_q <= recv_mem[recv_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (send_we) begin
      send_mem[send_tail_q] <= pending_word_q;
    end
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= cmd_q.now;
    end
    send_rd_q  <= send_mem[scan_idx_q];
    stamp_rd_q <= stamp_mem[scan_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmd_q          <= '0;
      recv_head_q    <= '0;
      recv_tail_q    <= '0;
      recv_used_q    <= '0;
      no_room_q      <= 1'b0;
      last_acked_q   <= '0;
      send_head_q    <= '0;
      send_tail_q    <= '0;
      send_used_q    <= '0;
      window_q       <= WIN_RESET;
      pending_q      <= 1'b0;
      pending_word_q <= '0;
      scan_idx_q     <= '0;
      scan_cnt_q     <= '0;
      hold_valid_q   <= 1'b0;
      hold_q         <= '0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
      out_last_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (produce) begin
        if (hold_valid_q) begin
          out_q      <= hold_q;
          out_last_q <= 1'b0;
        end
        hold_q       <= prod_res;
        hold_valid_q <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q.op)
            OP_DATA: begin
              if (can_produce) begin
                if (recv_room) begin
                  recv_tail_q <= ptr_next(recv_tail_q);
                  recv_used_q <= recv_used_q + CW'(1);
                end else begin
                  no_room_q <= 1'b1;
                end
                last_acked_q <= cmd_q.seq;
                state_q      <= S_FLUSH;
              end
            end
            OP_ACK: begin
              if (send_used_q != '0) begin
                send_head_q <= ptr_next(send_head_q);
                send_used_q <= send_used_q - CW'(1);
              end
              window_q <= cmd_q.win;
              state_q  <= S_IDLE;
            end
            OP_DUPACK: begin
              window_q <= cmd_q.win;
              state_q  <= S_IDLE;
            end
            OP_IDLE: begin
              if (no_room_q && recv_room) begin
                if (can_produce) begin
                  no_room_q <= 1'b0;
                  state_q   <= S_FLUSH;
                end
              end else begin
                state_q <= S_IDLE;
              end
            end
            OP_SCAN: begin
              scan_idx_q <= send_head_q;
              scan_cnt_q <= '0;
              state_q    <= S_SCAN_RD;
            end
            OP_SUBMIT: begin
              if (!pending_q) begin
                pending_q      <= 1'b1;
                pending_word_q <= cmd_q.word[MESSAGE_BITS-1:0];
              end
              state_q <= S_IDLE;
            end
            OP_TAKE: begin
              state_q <= (recv_used_q != '0) ? S_TAKE : S_IDLE;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_TAKE: begin
          if (can_produce) begin
            recv_head_q <= ptr_next(recv_head_q);
            recv_used_q <= recv_used_q - CW'(1);
            state_q     <= S_FLUSH;
          end
        end
        S_SCAN_RD: begin
          state_q <= (scan_cnt_q == send_used_q) ? S_SCAN_NEW : S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!due || can_produce) begin
            scan_idx_q <= ptr_next(scan_idx_q);
            scan_cnt_q <= scan_cnt_q + CW'(1);
            state_q    <= S_SCAN_RD;
          end
        end
        S_SCAN_NEW: begin
          if (send_ok) begin
            if (can_produce) begin
              send_tail_q <= ptr_next(send_tail_q);
              send_used_q <= send_used_q + CW'(1);
              pending_q   <= 1'b0;
              state_q     <= S_FLUSH;
            end
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!hold_valid_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_q        <= hold_q;
            out_last_q   <= 1'b1;
            hold_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/windowed_arq_transport_engine.sv =====
// Top level of the windowed ARQ transport engine for one connection.
// Instantiates warq_front, warq_cmd_fifo and warq_back; depends on warq_pkg.
//
//   Channel  Direction  Handshake                 Payload
//   s_axis   in         s_axis_tvalid/tready      tdata: seq, window, word, now
//                                                 tuser: func, packet kind
//   m_axis   out        m_axis_tvalid/tready      tdata: ack, free, message
//                                                 tuser: emit kind; tlast
//   cfg      in         cfg_valid/cfg_ready       cfg_data: resend timeout
//
// Each command is executed by the back end as a sequence of states; a scan tick
// visits every entry in the send store, reading each one from its store memories
// in a read state and then checking it in a check state. The two-entry command queue
// lets input beats be accepted while the back end works. A stalled output holds
// the back end once its output register and hold stage are full. Reset is
// asynchronous and needs no clearing pass; the stores are read only below their
// fill counts.
module windowed_arq_transport_engine import warq_pkg::*; #(
  parameter int BUFFER_DEPTH = 8,
  parameter int MESSAGE_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: packet_seq[15:0], packet_window[19:16], message_word[83:20],
  // now_seconds[115:84], zero fill above.
  input  logic [119:0] s_axis_tdata_i,
  // tuser: func[2:0], packet_kind[4:3].
  input  logic [4:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: ack_number[15:0], free_space[19:16], message_out[83:20],
  // zero fill above.
  output logic [87:0]  m_axis_tdata_o,
  // tuser: emit_kind[2:0].
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i
);

  logic [7:0] timeout_q;
  logic       push, full, pop, empty;
  cmd_t       push_cmd, pop_cmd;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  warq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  warq_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .empty_o    (empty)
  );

  warq_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .MESSAGE_BITS(MESSAGE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .timeout_i  (timeout_q),
    .empty_i    (empty),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_res_o  (res),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, res.msg, res.free, res.ack};
  assign m_axis_tuser_o = res.kind;

endmodule

// ===== tb/tb_windowed_arq_transport_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for windowed_arq_transport_engine: a scripted and a random
// command stream, with every emitted beat compared in order against a behavioral model
// or a scripted expectation. Depends on warq_pkg and the engine RTL.
module tb_windowed_arq_transport_engine;
  import warq_pkg::*;

  localparam int DEPTH         = 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 500;
  localparam int PHASE_ITEMS   = 72;

  localparam logic [2:0] FUNC_UNUSED  = 3'd5;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [3:0]  win;
    logic [63:0] word;
    logic [31:0] now;
  } cmd_beat_t;

  typedef struct packed {
    emit_e       kind;
    logic [15:0] ack;
    logic [3:0]  free;
    logic [63:0] msg;
    logic        last;
  } emission_t;

  typedef struct {
    cmd_beat_t beat;
    bit        typed;
    bit        has_emit;
    emission_t emit;
  } script_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [119:0] s_axis_tdata_i;
  logic [4:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [87:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_data_i;

  windowed_arq_transport_engine #(
    .BUFFER_DEPTH(DEPTH),
    .MESSAGE_BITS(64)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Model of the connection state.
  logic [63:0] rx_buf [DEPTH];
  int          rx_cnt;
  bit          rx_overrun;
  logic [15:0] ack_seq;
  logic [63:0] tx_buf [DEPTH];
  logic [31:0] tx_time [DEPTH];
  int          tx_cnt;
  int          peer_win;
  bit          queued;
  logic [63:0] queued_word;
  logic [7:0]  retx_age;

  emission_t   emit_q[$];
  script_row_t script_q[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          gap_pct = 20;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic [31:0] clock_s = 32'd0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic emission_t emission(emit_e kind, logic [15:0] ack, logic [3:0] free,
                                         logic [63:0] msg, logic last);
    emission_t e;
    e.kind = kind;
    e.ack  = ack;
    e.free = free;
    e.msg  = msg;
    e.last = last;
    return e;
  endfunction

  function automatic void engine_step(cmd_beat_t b, bit record);
    emission_t   out_q[$];
    logic [31:0] age;
    case (b.func)
      FUNC_PACKET: begin
        case (b.kind)
          KIND_DATA: begin
            if (rx_cnt < DEPTH) begin
              rx_buf[rx_cnt] = b.word;
              rx_cnt++;
            end else begin
              rx_overrun = 1'b1;
            end
            out_q.push_back(emission(EMIT_ACK, b.seq, 4'(DEPTH - rx_cnt), '0, 1'b0));
            ack_seq = b.seq;
          end
          KIND_ACK: begin
            if (tx_cnt > 0) begin
              for (int j = 1; j < tx_cnt; j++) begin
                tx_buf[j - 1]  = tx_buf[j];
                tx_time[j - 1] = tx_time[j];
              end
              tx_cnt--;
            end
            peer_win = b.win;
          end
          KIND_DUPACK: peer_win = b.win;
          default: ;
        endcase
      end
      FUNC_IDLE: begin
        if (rx_overrun && rx_cnt < DEPTH) begin
          out_q.push_back(emission(EMIT_DUPACK, ack_seq, 4'(DEPTH - rx_cnt), '0, 1'b0));
          rx_overrun = 1'b0;
        end
      end
      FUNC_SCAN: begin
        for (int j = 0; j < tx_cnt; j++) begin
          age = b.now - tx_time[j];
          if (age >= {24'd0, retx_age}) begin
            out_q.push_back(emission(EMIT_RESEND, '0, '0, tx_buf[j], 1'b0));
            tx_time[j] = b.now;
          end
        end
        if (queued && tx_cnt < peer_win && tx_cnt < DEPTH) begin
          out_q.push_back(emission(EMIT_SEND, '0, '0, queued_word, 1'b0));
          tx_buf[tx_cnt]  = queued_word;
          tx_time[tx_cnt] = b.now;
          tx_cnt++;
          queued = 1'b0;
        end
      end
      FUNC_SUBMIT: begin
        if (!queued) begin
          queued_word = b.word;
          queued = 1'b1;
        end
      end
      FUNC_TAKE: begin
        if (rx_cnt > 0) begin
          out_q.push_back(emission(EMIT_DELIVER, '0, '0, rx_buf[0], 1'b0));
          for (int j = 1; j < rx_cnt; j++) rx_buf[j - 1] = rx_buf[j];
          rx_cnt--;
        end
      end
      default: ;
    endcase
    if (out_q.size() > 0) out_q[out_q.size() - 1].last = 1'b1;
    if (record) foreach (out_q[i]) emit_q.push_back(out_q[i]);
  endfunction

  task automatic send_beat(cmd_beat_t b, bit typed, bit has_emit, emission_t typed_emit);
    s_axis_tdata_i  <= {4'd0, b.now, b.word, b.win, b.seq};
    s_axis_tuser_i  <= {b.kind, b.func};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    engine_step(b, !typed);
    if (typed && has_emit) emit_q.push_back(typed_emit);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (emit_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [7:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    retx_age = value;
  endtask

  task automatic add_row(logic [2:0] func, logic [1:0] kind, logic [15:0] seq,
                         logic [3:0] win, logic [63:0] word, logic [31:0] now,
                         bit typed, bit has_emit, emission_t e);
    script_row_t r;
    r.beat     = '{func: func, kind: kind, seq: seq, win: win, word: word, now: now};
    r.typed    = typed;
    r.has_emit = has_emit;
    r.emit     = e;
    script_q.push_back(r);
  endtask

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int        r;
    r      = $urandom_range(0, 99);
    b.seq  = 16'($urandom_range(0, 65535));
    b.win  = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(3, 8));
    b.word = {$urandom, $urandom};
    b.kind = KIND_DATA;
    b.now  = $urandom;
    if (r < 22) begin
      b.func = FUNC_PACKET;
    end else if (r < 32) begin
      b.func = FUNC_PACKET;
      b.kind = KIND_ACK;
    end else if (r < 37) begin
      b.func = FUNC_PACKET;
      b.kind = KIND_DUPACK;
    end else if (r < 40) begin
      b.func = FUNC_PACKET;
      b.kind = KIND_UNKNOWN;
    end else if (r < 50) begin
      b.func = FUNC_IDLE;
    end else if (r < 68) begin
      b.func = FUNC_SCAN;
      case ($urandom_range(0, 29))
        0:       clock_s = $urandom;
        1:       clock_s = $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        default: clock_s = clock_s + $urandom_range(0, 3);
      endcase
      b.now = clock_s;
    end else if (r < 82) begin
      b.func = FUNC_SUBMIT;
    end else if (r < 95) begin
      b.func = FUNC_TAKE;
    end else begin
      b.func = 3'($urandom_range(FUNC_UNUSED, 7));
    end
    b.kind = (b.func == FUNC_PACKET) ? b.kind : 2'($urandom_range(0, 3));
    return b;
  endfunction

  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    emission_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (emit_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual kind %0d ack %h free %0d msg %h last %b",
                 $time, m_axis_tuser_o, m_axis_tdata_o[15:0], m_axis_tdata_o[19:16],
                 m_axis_tdata_o[83:20], m_axis_tlast_o);
        fail_cnt++;
      end else begin
        want = emit_q.pop_front();
        check_field("emit_kind", 64'(want.kind), 64'(m_axis_tuser_o));
        check_field("ack_number", 64'(want.ack), 64'(m_axis_tdata_o[15:0]));
        check_field("free_space", 64'(want.free), 64'(m_axis_tdata_o[19:16]));
        check_field("message_out", want.msg, m_axis_tdata_o[83:20]);
        check_field("last_of_run", 64'(want.last), 64'(m_axis_tlast_o));
      end
    end
  end

  initial begin
    cmd_beat_t  b;
    int         done;
    logic [7:0] phase_timeout [5];
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    rx_cnt      = 0;
    rx_overrun  = 1'b0;
    ack_seq     = '0;
    tx_cnt      = 0;
    peer_win    = DEPTH;
    queued      = 1'b0;
    queued_word = '0;
    retx_age    = TIMEOUT_RESET;

    add_row(FUNC_TAKE, KIND_DATA, '0, '0, '0, '0, 1, 0, '0);
    add_row(FUNC_SCAN, KIND_DATA, '0, '0, '0, '0, 0, 0, '0);
    add_row(FUNC_PACKET, KIND_DATA, 16'hFFFF, 4'hF, '1, '1, 1, 1,
            emission(EMIT_ACK, 16'hFFFF, 4'd7, '0, 1'b1));
    add_row(FUNC_PACKET, KIND_DATA, '0, '0, '0, '0, 1, 1,
            emission(EMIT_ACK, 16'h0000, 4'd6, '0, 1'b1));
    repeat (6) add_row(FUNC_PACKET, KIND_DATA, 16'($urandom_range(0, 65535)), '0,
                       {$urandom, $urandom}, '0, 0, 0, '0);
    add_row(FUNC_PACKET, KIND_DATA, 16'h1234, '0, '1, '0, 1, 1,
            emission(EMIT_ACK, 16'h1234, 4'd0, '0, 1'b1));
    add_row(FUNC_IDLE, KIND_DATA, '0, '0, '0, '0, 1, 0, '0);
    add_row(FUNC_TAKE, KIND_DATA, '0, '0, '0, '0, 1, 1,
            emission(EMIT_DELIVER, '0, '0, '1, 1'b1));
    add_row(FUNC_IDLE, KIND_DATA, '0, '0, '0, '0, 1, 1,
            emission(EMIT_DUPACK, 16'h1234, 4'd1, '0, 1'b1));
    add_row(FUNC_SUBMIT, KIND_DATA, '0, '0, 64'h0123_4567_89AB_CDEF, '0, 0, 0, '0);
    add_row(FUNC_SUBMIT, KIND_DATA, '0, '0, 64'hDEAD_BEEF_0000_0001, '0, 0, 0, '0);
    add_row(FUNC_SCAN, KIND_DATA, '0, '0, '0, 32'd100, 1, 1,
            emission(EMIT_SEND, '0, '0, 64'h0123_4567_89AB_CDEF, 1'b1));
    add_row(FUNC_SCAN, KIND_DATA, '0, '0, '0, 32'd102, 1, 1,
            emission(EMIT_RESEND, '0, '0, 64'h0123_4567_89AB_CDEF, 1'b1));
    add_row(FUNC_PACKET, KIND_ACK, '0, 4'd0, '0, '0, 0, 0, '0);
    add_row(FUNC_SUBMIT, KIND_DATA, '0, '0, 64'h8000_0000_0000_0000, '0, 0, 0, '0);
    add_row(FUNC_SCAN, KIND_DATA, '0, '0, '0, 32'd200, 0, 0, '0);
    add_row(FUNC_PACKET, KIND_DUPACK, '0, 4'd15, '0, '0, 0, 0, '0);
    add_row(FUNC_SCAN, KIND_DATA, '0, '0, '0, 32'hFFFF_FFFF, 1, 1,
            emission(EMIT_SEND, '0, '0, 64'h8000_0000_0000_0000, 1'b1));
    add_row(FUNC_SCAN, KIND_DATA, '0, '0, '0, 32'd1, 1, 1,
            emission(EMIT_RESEND, '0, '0, 64'h8000_0000_0000_0000, 1'b1));
    add_row(FUNC_UNUSED, KIND_DATA, '0, '0, '0, '0, 1, 0, '0);
    add_row(FUNC_PACKET, KIND_UNKNOWN, '0, '0, '0, '0, 1, 0, '0);
    add_row(FUNC_PACKET, KIND_ACK, '0, 4'd8, '0, '0, 0, 0, '0);
    add_row(FUNC_PACKET, KIND_ACK, '0, 4'd8, '0, '0, 0, 0, '0);

    phase_timeout[0] = 8'd0;
    phase_timeout[1] = 8'd255;
    phase_timeout[2] = 8'd1;
    phase_timeout[3] = TIMEOUT_RESET;
    phase_timeout[4] = 8'($urandom_range(3, 254));

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (script_q[i])
      send_beat(script_q[i].beat, script_q[i].typed, script_q[i].has_emit, script_q[i].emit);

    for (int p = 0; p < 5; p++) begin
      settle();
      write_timeout(phase_timeout[p]);
      gap_pct = (p == 2) ? 0 : 20;
      if (p == 1) hold_req = 1'b1;
      if (p == 4) quiet = 1'b1;
      clock_s = $urandom;
      done = 0;
      while (done < PHASE_ITEMS) begin
        b = random_beat();
        send_beat(b, 0, 0, '0);
        if (b.func <= FUNC_TAKE && !(b.func == FUNC_PACKET && b.kind == KIND_UNKNOWN))
          done++;
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
